// ----- sv/bvf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the building visibility block.
// Depends on nothing; every other file of the block imports it.
package bvf_pkg;

   localparam int unsigned FIELD_W = 20;   // one 16.4 coordinate
   localparam int unsigned EDGE_W  = 21;   // left edge plus width
   localparam int unsigned POINT_W = 22;   // doubled midpoint
   localparam int unsigned NUM_W   = 7;    // building number on the result side

   // One loaded record as it travels from the front to the back.
   typedef struct packed {
      logic               store;   // record fits the store and is kept
      logic [FIELD_W-1:0] left;
      logic [FIELD_W-1:0] front;
      logic [FIELD_W-1:0] span;
      logic [FIELD_W-1:0] height;
      logic               last;    // closes the set
   } rec_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_OUT
   } state_type;

   // What one pass over the stored buildings is looking for.
   typedef enum logic [1:0] {
      PH_ORDER,   // next building in sorted order
      PH_EDGE,    // next distinct edge above the current one
      PH_CHECK    // a nearer building at least as tall hiding the midpoint
   } phase_type;

endpackage

// ----- sv/bvf_front.sv -----
`timescale 1ns / 1ps
// Front part: takes record beats, decides whether each fits the store.
// Depends on bvf_pkg.
module bvf_front
   import bvf_pkg::*;
#(
   parameter int unsigned MAX_BUILDINGS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_left_edge,
   input  logic [FIELD_W-1:0] req_front_distance,
   input  logic [FIELD_W-1:0] req_span_width,
   input  logic [FIELD_W-1:0] req_tower_height,
   input  logic               req_last_building,
   input  logic               q_full,
   output logic               q_push,
   output rec_type            q_rec
);

   localparam int unsigned CW = $clog2(MAX_BUILDINGS + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          fits;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;
   assign fits      = (count_ff < CW'(MAX_BUILDINGS));

   always_comb begin
      q_rec.store  = fits;
      q_rec.left   = req_left_edge;
      q_rec.front  = req_front_distance;
      q_rec.span   = req_span_width;
      q_rec.height = req_tower_height;
      q_rec.last   = req_last_building;
      count_in     = count_ff;
      if (q_push) begin
         if (req_last_building) begin
            count_in = '0;
         end else if (fits) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/bvf_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of records between the front and the back.
// Depends on bvf_pkg.
module bvf_queue
   import bvf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output rec_type head
);

   rec_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] used_ff, used_in;

   assign full      = (used_ff == 2'd2);
   assign not_empty = (used_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      used_in   = used_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into a full queue");
   queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("pop from an empty queue");
   queue_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (used_ff == $past(used_ff) + 2'd1))
      else $error("queue count did not follow a push");

endmodule

// ----- sv/bvf_back.sv -----
`timescale 1ns / 1ps
// Back part: holds the building store and runs the visibility walk.
// Depends on bvf_pkg.
module bvf_back
   import bvf_pkg::*;
#(
   parameter int unsigned MAX_BUILDINGS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  rec_type          q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [NUM_W-1:0] rsp_building_number,
   output logic             rsp_is_visible,
   output logic             rsp_last_result
);

   localparam int unsigned CW = $clog2(MAX_BUILDINGS + 1);
   localparam int unsigned IW = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1;
   localparam int unsigned KW = 2 * FIELD_W + IW;

   logic [FIELD_W-1:0] left_mem   [MAX_BUILDINGS];
   logic [FIELD_W-1:0] front_mem  [MAX_BUILDINGS];
   logic [FIELD_W-1:0] span_mem   [MAX_BUILDINGS];
   logic [FIELD_W-1:0] height_mem [MAX_BUILDINGS];

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      out_n_ff, out_n_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic [FIELD_W-1:0] rd_left_ff, rd_front_ff, rd_span_ff, rd_height_ff;

   logic               found_ff, found_in;
   logic [KW-1:0]      best_key_ff, best_key_in;
   logic [FIELD_W-1:0] best_span_ff, best_span_in;
   logic [FIELD_W-1:0] best_height_ff, best_height_in;
   logic [EDGE_W-1:0]  best_edge_ff, best_edge_in;

   logic               have_prev_ff, have_prev_in;
   logic [KW-1:0]      prev_key_ff, prev_key_in;
   logic [FIELD_W-1:0] k_span_ff, k_span_in;
   logic [FIELD_W-1:0] k_height_ff, k_height_in;
   logic               have_edge_ff, have_edge_in;
   logic [EDGE_W-1:0]  edge_ff, edge_in;
   logic [POINT_W-1:0] point_ff, point_in;
   logic               blocked_ff, blocked_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]   rsp_num_ff, rsp_num_in;
   logic               rsp_vis_ff, rsp_vis_in;
   logic               rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic [KW-1:0]      cand_key;
   logic [EDGE_W-1:0]  cand_lo, cand_hi;
   logic [FIELD_W-1:0] k_left, k_front;
   logic [IW-1:0]      k_idx;
   logic [POINT_W-1:0] new_point;
   logic               k_covers, m_covers, scan_done;

   assign q_pop               = (state_ff == ST_LOAD) && q_not_empty;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_building_number = rsp_num_ff;
   assign rsp_is_visible      = rsp_vis_ff;
   assign rsp_last_result     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (q_pop && q_head.store) begin
         left_mem[cnt_ff[IW-1:0]]   <= q_head.left;
         front_mem[cnt_ff[IW-1:0]]  <= q_head.front;
         span_mem[cnt_ff[IW-1:0]]   <= q_head.span;
         height_mem[cnt_ff[IW-1:0]] <= q_head.height;
      end
      rd_left_ff   <= left_mem[addr_ff[IW-1:0]];
      rd_front_ff  <= front_mem[addr_ff[IW-1:0]];
      rd_span_ff   <= span_mem[addr_ff[IW-1:0]];
      rd_height_ff <= height_mem[addr_ff[IW-1:0]];
   end

   always_comb begin
      cand_key  = {rd_left_ff, rd_front_ff, rd_idx_ff};
      cand_lo   = {1'b0, rd_left_ff};
      cand_hi   = EDGE_W'(rd_left_ff) + EDGE_W'(rd_span_ff);
      k_left    = prev_key_ff[KW-1 -: FIELD_W];
      k_front   = prev_key_ff[IW +: FIELD_W];
      k_idx     = prev_key_ff[IW-1:0];
      new_point = POINT_W'(edge_ff) + POINT_W'(best_edge_ff);
      k_covers  = (new_point >= {1'b0, k_left, 1'b0}) &&
                  (new_point <= {EDGE_W'(k_left) + EDGE_W'(k_span_ff), 1'b0});
      m_covers  = (point_ff >= {1'b0, rd_left_ff, 1'b0}) &&
                  (point_ff <= {cand_hi, 1'b0});
      scan_done = (addr_ff == cnt_ff) && !rd_vld_ff;
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      cnt_in         = cnt_ff;
      addr_in        = addr_ff;
      out_n_in       = out_n_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      found_in       = found_ff;
      best_key_in    = best_key_ff;
      best_span_in   = best_span_ff;
      best_height_in = best_height_ff;
      best_edge_in   = best_edge_ff;
      have_prev_in   = have_prev_ff;
      prev_key_in    = prev_key_ff;
      k_span_in      = k_span_ff;
      k_height_in    = k_height_ff;
      have_edge_in   = have_edge_ff;
      edge_in        = edge_ff;
      point_in       = point_ff;
      blocked_in     = blocked_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_num_in     = rsp_num_ff;
      rsp_vis_in     = rsp_vis_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (q_pop) begin
               if (q_head.store) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (q_head.last) begin
                  state_in     = ST_SCAN;
                  phase_in     = PH_ORDER;
                  addr_in      = '0;
                  found_in     = 1'b0;
                  have_prev_in = 1'b0;
                  out_n_in     = '0;
               end
            end
         end
         ST_SCAN: begin
            if (addr_ff != cnt_ff) begin
               addr_in   = addr_ff + 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = addr_ff[IW-1:0];
            end
            if (rd_vld_ff) begin
               case (phase_ff)
                  PH_ORDER: begin
                     if ((!have_prev_ff || cand_key > prev_key_ff) &&
                         (!found_ff || cand_key < best_key_ff)) begin
                        found_in       = 1'b1;
                        best_key_in    = cand_key;
                        best_span_in   = rd_span_ff;
                        best_height_in = rd_height_ff;
                     end
                  end
                  PH_EDGE: begin
                     // Both edges of the building are tested: left first, then right.
                     if ((!have_edge_ff || cand_lo > edge_ff) &&
                         (!found_ff || cand_lo < best_edge_ff)) begin
                        found_in     = 1'b1;
                        best_edge_in = cand_lo;
                     end
                     if ((!have_edge_ff || cand_hi > edge_ff) &&
                         (!found_in || cand_hi < best_edge_in)) begin
                        found_in     = 1'b1;
                        best_edge_in = cand_hi;
                     end
                  end
                  PH_CHECK: begin
                     if (rd_front_ff < k_front && rd_height_ff >= k_height_ff &&
                         m_covers) begin
                        blocked_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (scan_done) begin
               addr_in  = '0;
               found_in = 1'b0;
               case (phase_ff)
                  PH_ORDER: begin
                     have_prev_in = 1'b1;
                     prev_key_in  = best_key_ff;
                     k_span_in    = best_span_ff;
                     k_height_in  = best_height_ff;
                     if (out_n_ff == '0) begin
                        // The leading building in the order is always seen.
                        state_in     = ST_OUT;
                        rsp_valid_in = 1'b1;
                        rsp_num_in   = NUM_W'(best_key_ff[IW-1:0]) + 1'b1;
                        rsp_vis_in   = 1'b1;
                        rsp_last_in  = (out_n_ff + 1'b1 == cnt_ff);
                        out_n_in     = out_n_ff + 1'b1;
                     end else begin
                        phase_in     = PH_EDGE;
                        have_edge_in = 1'b0;
                     end
                  end
                  PH_EDGE: begin
                     if (!found_ff) begin
                        state_in     = ST_OUT;
                        rsp_valid_in = 1'b1;
                        rsp_num_in   = NUM_W'(k_idx) + 1'b1;
                        rsp_vis_in   = 1'b0;
                        rsp_last_in  = (out_n_ff + 1'b1 == cnt_ff);
                        out_n_in     = out_n_ff + 1'b1;
                     end else begin
                        have_edge_in = 1'b1;
                        edge_in      = best_edge_ff;
                        point_in     = new_point;
                        if (have_edge_ff && k_covers) begin
                           phase_in   = PH_CHECK;
                           blocked_in = 1'b0;
                        end
                     end
                  end
                  PH_CHECK: begin
                     if (!blocked_ff) begin
                        state_in     = ST_OUT;
                        rsp_valid_in = 1'b1;
                        rsp_num_in   = NUM_W'(k_idx) + 1'b1;
                        rsp_vis_in   = 1'b1;
                        rsp_last_in  = (out_n_ff + 1'b1 == cnt_ff);
                        out_n_in     = out_n_ff + 1'b1;
                     end else begin
                        phase_in = PH_EDGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
                  out_n_in = '0;
               end else begin
                  state_in = ST_SCAN;
                  phase_in = PH_ORDER;
                  addr_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         phase_ff     <= PH_ORDER;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         out_n_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         have_edge_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         out_n_ff     <= out_n_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         have_prev_ff <= have_prev_in;
         have_edge_ff <= have_edge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      best_key_ff    <= best_key_in;
      best_span_ff   <= best_span_in;
      best_height_ff <= best_height_in;
      best_edge_ff   <= best_edge_in;
      prev_key_ff    <= prev_key_in;
      k_span_ff      <= k_span_in;
      k_height_ff    <= k_height_in;
      edge_ff        <= edge_in;
      point_ff       <= point_in;
      blocked_ff     <= blocked_in;
      rsp_num_ff     <= rsp_num_in;
      rsp_vis_ff     <= rsp_vis_in;
      rsp_last_ff    <= rsp_last_in;
   end

   back_valid_only_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT)) else $error("result shown outside output state");
   back_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= cnt_ff) else $error("scan address beyond loaded count");
   back_results_bounded: assert property (@(posedge clock) disable iff (reset)
      out_n_ff <= cnt_ff) else $error("more results than buildings");
   back_no_pop_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> !q_pop) else $error("record taken during the walk");

endmodule

// ----- sv/building_visibility_from_front.sv -----
`timescale 1ns / 1ps
// Building visibility from the front. Record beats on the req_ channel load up
// to MAX_BUILDINGS buildings (left edge, front distance, width, height, all
// unsigned 16.4); records past the store limit are dropped, and the beat with
// req_last_building set closes the set. The block then returns one rsp_ beat
// per stored building, ordered by left edge, then front distance, then input
// order, carrying the building's input position (from 1), a visible flag and
// a last flag on the final beat. Loading runs at one beat per cycle through a
// two-entry record queue, so the input only stalls while a walk is running or
// its result beats are waiting to be taken.
// The walk makes repeated passes over the store, one entry per cycle through
// a single read port: picking each building takes one pass, and each
// elementary interval tested for a building takes one pass to find its upper
// edge and another to check for a hiding building. The first record of the
// next set may be accepted while a walk is running.
// Depends on bvf_pkg, bvf_front, bvf_queue and bvf_back.
module building_visibility_from_front
   import bvf_pkg::*;
#(
   parameter int unsigned MAX_BUILDINGS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_left_edge,
   input  logic [FIELD_W-1:0] req_front_distance,
   input  logic [FIELD_W-1:0] req_span_width,
   input  logic [FIELD_W-1:0] req_tower_height,
   input  logic               req_last_building,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [NUM_W-1:0]   rsp_building_number,
   output logic               rsp_is_visible,
   output logic               rsp_last_result
);

   // Records pass from the front to the back through the queue.
   logic    q_push, q_full, q_pop, q_not_empty;
   rec_type q_rec, q_head;

   bvf_front #(.MAX_BUILDINGS(MAX_BUILDINGS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_edge      (req_left_edge),
      .req_front_distance (req_front_distance),
      .req_span_width     (req_span_width),
      .req_tower_height   (req_tower_height),
      .req_last_building  (req_last_building),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_rec              (q_rec)
   );

   bvf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (q_rec),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // The back owns the store and answers on the rsp_ channel.
   bvf_back #(.MAX_BUILDINGS(MAX_BUILDINGS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_not_empty         (q_not_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_building_number (rsp_building_number),
      .rsp_is_visible      (rsp_is_visible),
      .rsp_last_result     (rsp_last_result)
   );

endmodule
